// File: src/sha256_stream_hasher_top_defines.svh
// ----------------------------------------------------------------------------
// SHA-256 hasher assertion macros
// Shared assertion helpers for the hasher top level.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_STREAM_HASHER_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SHS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/shs_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Types, constants and round functions shared by the hasher modules.
// ----------------------------------------------------------------------------
`default_nettype none
package shs_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef enum logic {
        CMD_DATA   = 1'b0,
        CMD_FINISH = 1'b1
    } cmd_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } eng_state_t;

    // queue status passed from front to back
    typedef struct packed {
        logic     valid;
        in_item_t item;
    } q_head_t;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
        ror = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] v);
        ssig0 = ror(v, 7) ^ ror(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] v);
        ssig1 = ror(v, 17) ^ ror(v, 19) ^ (v >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] v);
        bsig0 = ror(v, 2) ^ ror(v, 13) ^ ror(v, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] v);
        bsig1 = ror(v, 6) ^ ror(v, 11) ^ ror(v, 25);
    endfunction

endpackage
`default_nettype wire

// File: src/shs_stream_if.sv
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one word of payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface shs_in_if;
    import shs_pkg::*;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;
    modport source (output valid, cmd, data_byte, input ready);
    modport sink   (input valid, cmd, data_byte, output ready);
endinterface

interface shs_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last;
    modport source (output valid, digest_word, word_index, last, input ready);
    modport sink   (input valid, digest_word, word_index, last, output ready);
endinterface
`default_nettype wire

// File: src/shs_front.sv
// ----------------------------------------------------------------------------
// Hasher front end
// Accepts input words and queues them for the compression engine.
// ----------------------------------------------------------------------------
`default_nettype none
module shs_front
    import shs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    shs_in_if.sink      in_ch,
    input  wire logic   pop,
    output q_head_t     head
);
    in_item_t             q_mem [QDEPTH];
    logic [QAW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]         count_reg;
    logic                 push;

    assign in_ch.ready = (count_reg != QAW'(0) + (QAW+1)'(QDEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign head.valid  = (count_reg != '0);
    assign head.item   = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{cmd: in_ch.cmd, data_byte: in_ch.data_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

// File: src/shs_engine.sv
// ----------------------------------------------------------------------------
// Hasher back end
// Block buffer, padding sequencer, one-round-per-cycle compression, digest out.
// ----------------------------------------------------------------------------
`default_nettype none
module shs_engine
    import shs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  q_head_t     head,
    output logic        pop,
    shs_out_if.source   out_ch
);
    eng_state_t   state_reg, state_next;
    logic [31:0]  w_reg [16];      // 16-word schedule window, bytes shifted in
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [5:0]   fill_reg;
    logic [63:0]  bits_reg;
    logic [5:0]   rnd_reg;
    logic [1:0]   emit_reg;
    logic         fin_reg;         // compression is part of a finish
    logic         len_blk_reg;     // block being compressed carries the length

    logic         shift_en;
    logic [7:0]   shift_byte;
    logic [31:0]  t1, t2, w_new;

    assign t1 = v_reg[7] + bsig1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + K_TAB[rnd_reg] + w_reg[0];
    assign t2 = bsig0(v_reg[0]) + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2])
              ^ (v_reg[1] & v_reg[2]));
    assign w_new = ssig1(w_reg[14]) + w_reg[9] + ssig0(w_reg[1]) + w_reg[0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (head.valid)
                begin
                    if (fill_reg == 6'd63)
                        state_next = ST_ROUND;
                    else if (head.item.cmd == CMD_FINISH)
                    begin
                        // pad byte lands on byte 55: length follows at once
                        if (fill_reg == 6'd55)
                            state_next = ST_LEN;
                        else
                            state_next = ST_PAD;
                    end
                end
            ST_PAD:
                if (fill_reg == 6'd63)
                    state_next = ST_ROUND;
                else if (fill_reg == 6'd55)
                    state_next = ST_LEN;
            ST_LEN:
                if (fill_reg == 6'd63)
                    state_next = ST_ROUND;
            ST_ROUND:
                if (rnd_reg == 6'd63)
                    state_next = ST_ADD;
            ST_ADD:
                if (!fin_reg)
                    state_next = ST_IDLE;
                else if (!len_blk_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_EMIT;
            ST_EMIT:
                if (out_ch.ready && emit_reg == 2'd3)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        shift_en   = 1'b0;
        shift_byte = 8'h00;
        unique case (state_reg)
            ST_IDLE:
                if (head.valid)
                begin
                    pop        = 1'b1;
                    shift_en   = 1'b1;
                    shift_byte = (head.item.cmd == CMD_FINISH) ? PAD_BYTE : head.item.data_byte;
                end
            ST_PAD:
                shift_en = 1'b1;
            ST_LEN:
            begin
                shift_en   = 1'b1;
                shift_byte = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign out_ch.valid       = (state_reg == ST_EMIT);
    assign out_ch.digest_word = {h_reg[{emit_reg, 1'b0}], h_reg[{emit_reg, 1'b1}]};
    assign out_ch.word_index  = emit_reg;
    assign out_ch.last        = (emit_reg == 2'd3);

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= {w_reg[i][23:0], w_reg[i+1][31:24]};
            w_reg[15] <= {w_reg[15][23:0], shift_byte};
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            bits_reg    <= '0;
            rnd_reg     <= '0;
            emit_reg    <= '0;
            fin_reg     <= 1'b0;
            len_blk_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= H_INIT[i];
                v_reg[i] <= H_INIT[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            if (shift_en)
                fill_reg <= fill_reg + 6'd1;
            if (state_reg == ST_IDLE && head.valid)
            begin
                if (head.item.cmd == CMD_DATA)
                    bits_reg <= bits_reg + 64'd8;
                fin_reg <= (head.item.cmd == CMD_FINISH);
            end
            if (state_next == ST_ROUND && state_reg != ST_ROUND)
            begin
                rnd_reg     <= '0;
                len_blk_reg <= (state_reg == ST_LEN);
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
            end
            else if (state_reg == ST_ROUND)
            begin
                rnd_reg  <= rnd_reg + 6'd1;
                v_reg[0] <= t1 + t2;
                v_reg[1] <= v_reg[0];
                v_reg[2] <= v_reg[1];
                v_reg[3] <= v_reg[2];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[5] <= v_reg[4];
                v_reg[6] <= v_reg[5];
                v_reg[7] <= v_reg[6];
            end
            if (state_reg == ST_ADD)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
                emit_reg <= '0;
            end
            if (state_reg == ST_EMIT && out_ch.ready)
            begin
                emit_reg <= emit_reg + 2'd1;
                if (emit_reg == 2'd3)
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= H_INIT[i];
                    bits_reg <= '0;
                    fill_reg <= '0;
                    fin_reg  <= 1'b0;
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: src/sha256_stream_hasher_top.sv
// A data word is shifted into the block buffer; one that completes a block
// starts a compression. A finish word runs the pad and length fill, one or two
// compressions, then four digest words at one per accepted cycle.
// Rate is set by the single round unit: 1 round per cycle.
// Reset (rst_n, async low) loads the initial hash and clears all counters.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher top
// Queueing front end feeding a sequenced compression engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_stream_hasher_top_defines.svh"
module sha256_stream_hasher_top
    import shs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    shs_in_if.sink    in_ch,
    shs_out_if.source out_ch
);
    q_head_t head;
    logic    pop;

    shs_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .pop   (pop),
        .head  (head)
    );

    shs_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

    `SHS_ASSERT_IMP(a_pop_needs_head, pop, head.valid, "pop from empty queue")
    `SHS_ASSERT_NEXT(a_last_closes, out_ch.valid && out_ch.ready && out_ch.last,
        !out_ch.valid, "digest continues after last word")
    `SHS_ASSERT_IMP(a_no_pop_emit, out_ch.valid, !pop, "input taken during digest output")
endmodule
`default_nettype wire

// File: verif/sha256_stream_hasher_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Drives byte and finish words into the hasher with random gaps, hashes the
// same stream in a local model and compares every digest word in order.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top_tb;
    import shs_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last;
    } digest_exp_t;

    logic clk;
    logic rst_n;

    shs_in_if  in_ch ();
    shs_out_if out_ch ();

    sha256_stream_hasher_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // local hash state
    logic [31:0] hstate [8];
    logic [7:0]  blk [64];
    int          fill;
    logic [63:0] msg_bits;

    in_item_t    pending_q [$];
    digest_exp_t digest_q [$];
    int          mismatches;
    int          idle_cycles;
    bit          stim_done;
    bit          hold_off_req;
    bit          tx_taken;
    int          hold_cnt;
    int          tx_gap;
    int          rx_gap;

    function automatic logic [31:0] rotr(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic hash_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        for (int r = 16; r < 64; r++)
            w[r] = w[r-16] + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3))
                 + w[r-7] + (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10));
        a = hstate[0]; b = hstate[1]; c = hstate[2]; d = hstate[3];
        e = hstate[4]; f = hstate[5]; g = hstate[6]; h = hstate[7];
        for (int r = 0; r < 64; r++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + K_TAB[r] + w[r];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hstate[0] += a; hstate[1] += b; hstate[2] += c; hstate[3] += d;
        hstate[4] += e; hstate[5] += f; hstate[6] += g; hstate[7] += h;
    endtask

    task automatic clear_hash();
        for (int i = 0; i < 8; i++)
            hstate[i] = H_INIT[i];
        fill = 0;
        msg_bits = '0;
    endtask

    task automatic hash_word(in_item_t it);
        digest_exp_t e;
        if (it.cmd == CMD_DATA)
        begin
            blk[fill] = it.data_byte;
            fill++;
            msg_bits += 64'd8;
            if (fill == 64)
            begin
                hash_block();
                fill = 0;
            end
        end
        else
        begin
            blk[fill] = PAD_BYTE;
            fill++;
            if (fill > 56)
            begin
                while (fill < 64) blk[fill++] = 8'h00;
                hash_block();
                fill = 0;
            end
            while (fill < 56) blk[fill++] = 8'h00;
            for (int k = 0; k < 8; k++)
                blk[56+k] = msg_bits[63-8*k -: 8];
            hash_block();
            for (int k = 0; k < 4; k++)
            begin
                e.digest_word = {hstate[2*k], hstate[2*k+1]};
                e.word_index  = 2'(k);
                e.last        = (k == 3);
                digest_q.push_back(e);
            end
            clear_hash();
        end
    endtask

    function automatic in_item_t data_word(logic [7:0] b);
        in_item_t it;
        it.cmd = CMD_DATA;
        it.data_byte = b;
        return it;
    endfunction

    function automatic in_item_t finish_word();
        in_item_t it;
        it.cmd = CMD_FINISH;
        it.data_byte = 8'($urandom);
        return it;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // sender
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.cmd       <= CMD_DATA;
            in_ch.data_byte <= '0;
            tx_gap          <= 0;
            tx_taken         = 1'b0;
        end
        else if (in_ch.valid && !tx_taken)
        begin
            // hold the offered word until it is taken
        end
        else
        begin
            tx_taken = 1'b0;
            if (tx_gap > 0)
            begin
                in_ch.valid <= 1'b0;
                tx_gap      <= tx_gap - 1;
            end
            else if (pending_q.size() > 0)
            begin
                in_ch.valid     <= 1'b1;
                in_ch.cmd       <= pending_q[0].cmd;
                in_ch.data_byte <= pending_q[0].data_byte;
                tx_gap          <= pick_gap();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // acceptance on the input side feeds the model
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            tx_taken = 1'b1;
            hash_word(pending_q.pop_front());
        end
    end

    // receiver stalls
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            rx_gap       <= 0;
            hold_cnt     <= 0;
        end
        else if (hold_off_req || hold_cnt > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_cnt     <= hold_off_req && hold_cnt == 0 ? 1500 : hold_cnt - 1;
        end
        else if (rx_gap > 0)
        begin
            out_ch.ready <= 1'b0;
            rx_gap       <= rx_gap - 1;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            rx_gap       <= pick_gap();
        end
    end

    // monitor
    always @(posedge clk)
    begin
        digest_exp_t exp_w;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (digest_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest word %h idx %0d", out_ch.digest_word,
                             out_ch.word_index);
            end
            else
            begin
                exp_w = digest_q.pop_front();
                if (out_ch.digest_word !== exp_w.digest_word ||
                    out_ch.word_index !== exp_w.word_index || out_ch.last !== exp_w.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                                 exp_w.digest_word, exp_w.word_index, exp_w.last,
                                 out_ch.digest_word, out_ch.word_index, out_ch.last);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic queue_message(int len);
        for (int i = 0; i < len; i++)
            pending_q.push_back(data_word(8'($urandom)));
        pending_q.push_back(finish_word());
    endtask

    initial
    begin
        int lengths [$];
        int total;
        rst_n        = 1'b0;
        mismatches   = 0;
        idle_cycles  = 0;
        stim_done    = 1'b0;
        hold_off_req = 1'b0;
        clear_hash();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty message, then short ones with extreme bytes
        pending_q.push_back(finish_word());
        pending_q.push_back(data_word(8'h00));
        pending_q.push_back(finish_word());
        pending_q.push_back(data_word(8'hff));
        pending_q.push_back(data_word(8'h55));
        pending_q.push_back(data_word(8'haa));
        pending_q.push_back(finish_word());
        // back-to-back finishes while the receiver holds off
        pending_q.push_back(finish_word());
        pending_q.push_back(finish_word());
        pending_q.push_back(finish_word());
        hold_off_req = 1'b1;
        @(posedge clk);
        @(posedge clk);
        hold_off_req = 1'b0;
        wait (pending_q.size() == 0 && digest_q.size() == 0);

        // padding boundaries: 55, 56, 63 and 64 bytes, all but the first spilling into a second block
        lengths = '{55, 56, 63, 64};
        foreach (lengths[i])
            queue_message(lengths[i]);
        total = 0;
        while (total < 8)
        begin
            int n;
            n = $urandom_range(0, 5);
            queue_message(n);
            total += n + 1;
        end
        wait (pending_q.size() == 0 && digest_q.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/shs_pkg.sv
src/shs_stream_if.sv
src/shs_front.sv
src/shs_engine.sv
src/sha256_stream_hasher_top.sv
verif/sha256_stream_hasher_top_tb.sv
